// ===== sv/two_channel_tint_blend_macros.svh =====
// Assertion macros shared by the tint blend RTL.
`ifndef TWO_CHANNEL_TINT_BLEND_MACROS_SVH
`define TWO_CHANNEL_TINT_BLEND_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TCTB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TCTB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tctb_pkg.sv =====
// Shared types and constants of the two-channel tint blend.
`timescale 1ns / 1ps

package tctb_pkg;

  // Field widths
  localparam int LEVEL_W = 16;
  localparam int BLEND_W = 8;
  localparam int GAIN_W  = 7;
  localparam int HSL_W   = 8;

  // Port widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;

  // Pipeline depth from input register to output register
  localparam int NSTAGE = 9;

  // Divide-by-255 unit: dividend and quotient widths
  localparam int DIV_XW = 25;
  localparam int DIV_QW = 18;
  // floor(2^24 / 255); estimate lands on q or q-1 for dividends below 2^25
  localparam int RECIP_SHIFT = 24;
  localparam logic [16:0] RECIP_255 = 17'd65793;
  localparam logic [7:0]  FULL_SCALE = 8'd255;
  localparam logic [6:0]  ROUND_HALF = 7'd127;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET = 7'd26;
  localparam logic [HSL_W-1:0]  HSL_RESET  = 8'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CORRECTION_GAIN  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_SPEED_LEVEL = 8'd1;

  // Stage enables of a two-step divide unit
  typedef struct packed {
    logic est;
    logic fix;
  } div_en_t;

endpackage

// ===== sv/two_channel_tint_blend.sv =====
// Two-channel tint blend: split brightness between warm and cool PWM channels.
// Throughput: one word per cycle while the output is ready; the nine-stage
// pipeline stalls stage by stage, so bubbles fill up while the output waits.
// Reset clears all stage valid bits; correction_gain returns to 26 and
// half_speed_level to 0.
`timescale 1ns / 1ps

module two_channel_tint_blend import tctb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // brightness[15:0], channel_top[31:16], blend[39:32], ramp_level[47:40]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // warm_level[15:0], cool_level[31:16]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  `include "two_channel_tint_blend_macros.svh"

  // Configuration registers
  logic [GAIN_W-1:0] correction_gain;
  logic [HSL_W-1:0]  half_speed_level;

  // Pipeline control
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  // Input fields
  logic [LEVEL_W-1:0] in_b;
  logic [LEVEL_W-1:0] in_top;
  logic [BLEND_W-1:0] in_blend;
  logic [BLEND_W-1:0] in_ramp;
  logic [BLEND_W-1:0] in_lvl;
  logic [BLEND_W-1:0] in_tri;
  logic [LEVEL_W-1:0] in_excess;

  // Stage registers
  logic [LEVEL_W-1:0] b_s1, b_s2, b_s3, b_s4;
  logic [LEVEL_W-1:0] top_s1, top_s2, top_s3, top_s4, top_s5, top_s6, top_s7, top_s8;
  logic [LEVEL_W-1:0] top_s9;
  logic [BLEND_W-1:0] blend_s1, blend_s2, blend_s3, blend_s4, blend_s5;
  logic [BLEND_W-1:0] tri_s1;
  logic               boost_s1, boost_s2, boost_s3, boost_s4;
  logic [22:0]        m1_s1, m2_s1;
  logic [DIV_XW-1:0]  p1_s2, p2_s2;
  logic [16:0]        base_s5, base_s6, base_s7, base_s8, base_s9;
  logic [DIV_XW-1:0]  x_s6;
  logic [LEVEL_W-1:0] warm_s9, cool_s9;

  // Divider results
  logic [DIV_QW-1:0] boost_q, pen_q, cool_q;
  div_en_t           div_en_a, div_en_c;

  // Combinational values
  logic signed [19:0] sum;
  logic [16:0]        top2;
  logic [16:0]        base_next;
  logic [16:0]        cool_w, warm_w;
  logic [LEVEL_W-1:0] warm_next, cool_next;

  // Configuration write port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      correction_gain  <= GAIN_RESET;
      half_speed_level <= HSL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CORRECTION_GAIN:  correction_gain  <= cfg_data[GAIN_W-1:0];
        CFG_HALF_SPEED_LEVEL: half_speed_level <= cfg_data[HSL_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage advances when empty or when its successor advances
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || m_axis_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[NSTAGE-1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Unpack the input word
  assign in_b     = s_axis_tdata[15:0];
  assign in_top   = s_axis_tdata[31:16];
  assign in_blend = s_axis_tdata[39:32];
  assign in_ramp  = s_axis_tdata[47:40];
  assign in_lvl   = in_ramp - 1'b1;
  // Triangle peaks at the middle tint; 255 - 2x is the complement of 2x
  assign in_tri   = in_blend[7] ? ~{in_blend[6:0], 1'b0} : {in_blend[6:0], 1'b0};
  assign in_excess = (in_b > in_top) ? (in_b - in_top) : '0;

  // Stage 1: gain products of brightness and excess
  always_ff @(posedge clk) begin
    if (en[0]) begin
      b_s1     <= in_b;
      top_s1   <= in_top;
      blend_s1 <= in_blend;
      tri_s1   <= in_tri;
      boost_s1 <= in_lvl > half_speed_level;
      m1_s1    <= in_b * correction_gain;
      m2_s1    <= in_excess * correction_gain;
    end
  end

  // Stage 2: scale by the triangle
  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_s2     <= b_s1;
      top_s2   <= top_s1;
      blend_s2 <= blend_s1;
      boost_s2 <= boost_s1;
      p1_s2    <= m1_s1[22:6] * tri_s1;
      p2_s2    <= m2_s1[22:6] * tri_s1;
    end
  end

  // Stages 3 and 4: divide both terms by 255
  assign div_en_a = '{est: en[2], fix: en[3]};

  tctb_div255 u_div_boost (
    .clk (clk),
    .en  (div_en_a),
    .x   (p1_s2),
    .q   (boost_q)
  );

  tctb_div255 u_div_pen (
    .clk (clk),
    .en  (div_en_a),
    .x   (p2_s2),
    .q   (pen_q)
  );

  always_ff @(posedge clk) begin
    if (en[2]) begin
      b_s3     <= b_s2;
      top_s3   <= top_s2;
      blend_s3 <= blend_s2;
      boost_s3 <= boost_s2;
    end
    if (en[3]) begin
      b_s4     <= b_s3;
      top_s4   <= top_s3;
      blend_s4 <= blend_s3;
      boost_s4 <= boost_s3;
    end
  end

  // Stage 5: add boost, drop twice the penalty, clamp to 0 .. 2*top
  always_comb begin
    top2 = {top_s4, 1'b0};
    sum  = $signed({4'b0, b_s4}) - $signed({1'b0, pen_q, 1'b0});
    if (boost_s4) begin
      sum = sum + $signed({2'b0, boost_q});
    end
    if (sum < 0) begin
      base_next = '0;
    end else if (sum > $signed({3'b0, top2})) begin
      base_next = top2;
    end else begin
      base_next = sum[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      base_s5  <= base_next;
      top_s5   <= top_s4;
      blend_s5 <= blend_s4;
    end
  end

  // Stage 6: rounded numerator of the cool share
  always_ff @(posedge clk) begin
    if (en[5]) begin
      x_s6    <= blend_s5 * base_s5 + {{(DIV_XW-7){1'b0}}, ROUND_HALF};
      base_s6 <= base_s5;
      top_s6  <= top_s5;
    end
  end

  // Stages 7 and 8: divide the numerator by 255
  assign div_en_c = '{est: en[6], fix: en[7]};

  tctb_div255 u_div_cool (
    .clk (clk),
    .en  (div_en_c),
    .x   (x_s6),
    .q   (cool_q)
  );

  always_ff @(posedge clk) begin
    if (en[6]) begin
      base_s7 <= base_s6;
      top_s7  <= top_s6;
    end
    if (en[7]) begin
      base_s8 <= base_s7;
      top_s8  <= top_s7;
    end
  end

  // Stage 9: split and spill a channel over top into the other
  always_comb begin
    cool_w = cool_q[16:0];
    warm_w = base_s8 - cool_w;
    if (cool_w > {1'b0, top_s8}) begin
      warm_next = 16'(base_s8 - {1'b0, top_s8});
      cool_next = top_s8;
    end else if (warm_w > {1'b0, top_s8}) begin
      cool_next = 16'(base_s8 - {1'b0, top_s8});
      warm_next = top_s8;
    end else begin
      warm_next = warm_w[15:0];
      cool_next = cool_w[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      warm_s9 <= warm_next;
      cool_s9 <= cool_next;
      base_s9 <= base_s8;
      top_s9  <= top_s8;
    end
  end

  assign m_axis_tdata = {cool_s9, warm_s9};

  // Checks
  `TCTB_ASSERT(a_levels_within_top,
    m_axis_tvalid |-> (warm_s9 <= top_s9) && (cool_s9 <= top_s9),
    "channel level above channel top")
  `TCTB_ASSERT(a_split_keeps_base,
    m_axis_tvalid |-> ({1'b0, warm_s9} + {1'b0, cool_s9} == base_s9),
    "warm plus cool differs from clamped base")
  `TCTB_ASSERT_ALWAYS(a_reset_empties_pipe,
    rst |=> !m_axis_tvalid && !vld[0],
    "pipeline holds a word after reset")

endmodule

// ===== sv/tctb_div255.sv =====
// Two-stage divide by 255: reciprocal estimate, then one correction step.
`timescale 1ns / 1ps

module tctb_div255 import tctb_pkg::*; (
  input  logic              clk,
  input  div_en_t           en,
  input  logic [DIV_XW-1:0] x,
  output logic [DIV_QW-1:0] q
);

  logic [DIV_XW-1:0]            x_a;
  logic [DIV_QW-1:0]            q_a;
  logic [DIV_XW+16:0]           prod;
  logic [DIV_XW:0]              q255;
  logic [DIV_XW:0]              rem;

  // Estimate the quotient by the truncated reciprocal
  assign prod = x * RECIP_255;

  always_ff @(posedge clk) begin
    if (en.est) begin
      x_a <= x;
      q_a <= prod[RECIP_SHIFT +: DIV_QW];
    end
  end

  // Bump the estimate when the remainder reaches the divisor
  assign q255 = {q_a, 8'b0} - {{(DIV_XW+1-DIV_QW){1'b0}}, q_a};
  assign rem  = {1'b0, x_a} - q255;

  always_ff @(posedge clk) begin
    if (en.fix) begin
      if (rem >= {{(DIV_XW-7){1'b0}}, FULL_SCALE}) begin
        q <= q_a + 1'b1;
      end else begin
        q <= q_a;
      end
    end
  end

endmodule

// ===== bench/two_channel_tint_blend_tb.sv =====
// Self-checking testbench for the two-channel tint blend with random stalls on both streams.
`timescale 1ns / 1ps

module two_channel_tint_blend_tb;
  import tctb_pkg::*;

  localparam longint GAIN_DIV = 64;
  localparam longint SCALE    = FULL_SCALE;
  localparam longint ROUNDING = ROUND_HALF;

  typedef struct {
    logic [LEVEL_W-1:0] brightness;
    logic [LEVEL_W-1:0] channel_top;
    logic [BLEND_W-1:0] blend;
    logic [7:0]         ramp_level;
  } tint_req_t;

  typedef struct {
    logic [LEVEL_W-1:0] warm_level;
    logic [LEVEL_W-1:0] cool_level;
  } level_pair_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow copy of the registers, updated when a write is accepted
  logic [GAIN_W-1:0] gain_shadow = GAIN_RESET;
  logic [HSL_W-1:0]  hsl_shadow  = HSL_RESET;

  tint_req_t   pending_reqs[$];
  level_pair_t levels_due[$];
  int          fail_count = 0;
  int          in_wait = 0;
  int          in_calm = 0;
  int          out_wait = 0;
  int          out_calm = 0;
  bit          in_taken = 1'b0;

  two_channel_tint_blend u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // Wait before the next word: mostly random, with occasional runs of back-to-back words
  function automatic int pick_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 17);
  endfunction

  // Expected warm/cool split for one request under the current register values
  function automatic level_pair_t split_levels(tint_req_t r);
    longint      b, top, tri_val, gain, base, cool, warm;
    logic [7:0]  lvl;
    logic [7:0]  twice;
    level_pair_t res;
    b       = longint'(r.brightness);
    top     = longint'(r.channel_top);
    gain    = longint'(gain_shadow);
    lvl     = r.ramp_level - 8'd1;
    twice   = {r.blend[6:0], 1'b0};
    tri_val = longint'((r.blend < 8'd128) ? twice : 8'(8'd255 - twice));
    base    = b;
    // Mid-tint boost above the ramp threshold
    if (lvl > hsl_shadow) base = b + ((b * gain / GAIN_DIV) * tri_val / SCALE);
    // Pull back twice the boost on the part above the channel top
    if (b > top) base -= 2 * (((b - top) * gain / GAIN_DIV) * tri_val / SCALE);
    if (base > 2 * top) base = 2 * top;
    if (base < 0) base = 0;
    cool = (longint'(r.blend) * base + ROUNDING) / SCALE;
    warm = base - cool;
    // Spill whatever exceeds the top into the other channel
    if (cool > top) begin
      warm += cool - top;
      cool = top;
    end else if (warm > top) begin
      cool += warm - top;
      warm = top;
    end
    res.warm_level = warm[LEVEL_W-1:0];
    res.cool_level = cool[LEVEL_W-1:0];
    return res;
  endfunction

  function automatic tint_req_t draw_req();
    tint_req_t r;
    case ($urandom_range(0, 9))
      0:       r.brightness = 16'hFFFF;
      1:       r.brightness = 16'($urandom_range(0, 255));
      2:       r.brightness = 16'h0000;
      default: r.brightness = 16'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0:       r.channel_top = 16'h0000;
      1:       r.channel_top = 16'hFFFF;
      2:       r.channel_top = r.brightness + 16'($urandom_range(0, 64)) - 16'd32;
      3:       r.channel_top = r.brightness >> $urandom_range(1, 3);
      default: r.channel_top = 16'($urandom());
    endcase
    case ($urandom_range(0, 7))
      0:       r.blend = 8'd0;
      1:       r.blend = 8'd255;
      2:       r.blend = 8'd127 + 8'($urandom_range(0, 1));
      default: r.blend = 8'($urandom());
    endcase
    case ($urandom_range(0, 7))
      0:       r.ramp_level = 8'd0;
      1:       r.ramp_level = hsl_shadow + 8'($urandom_range(0, 2));
      default: r.ramp_level = 8'($urandom());
    endcase
    return r;
  endfunction

  task automatic push_req(input int b, input int top, input int bl, input int ramp);
    tint_req_t r;
    r.brightness  = 16'(b);
    r.channel_top = 16'(top);
    r.blend       = 8'(bl);
    r.ramp_level  = 8'(ramp);
    pending_reqs.push_back(r);
  endtask

  task automatic queue_random(input int n);
    repeat (n) pending_reqs.push_back(draw_req());
  endtask

  // Hold until every queued word has gone through and the pipeline is empty
  task automatic drain();
    while (pending_reqs.size() != 0 || s_axis_tvalid || levels_due.size() != 0)
      @(posedge clk);
    repeat (NSTAGE + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_CORRECTION_GAIN) gain_shadow = val[GAIN_W-1:0];
    else if (idx == CFG_HALF_SPEED_LEVEL) hsl_shadow = val[HSL_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] gain_word,
                          input logic [CFG_DATA_W-1:0] hsl_word);
    drain();
    write_reg(CFG_CORRECTION_GAIN, gain_word);
    write_reg(CFG_HALF_SPEED_LEVEL, hsl_word);
  endtask

  // Input side: present queued words, idling between them
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (in_wait > 0) begin
        in_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        tint_req_t r;
        r = pending_reqs.pop_front();
        s_axis_tdata  <= {r.ramp_level, r.blend, r.channel_top, r.brightness};
        s_axis_tvalid <= 1'b1;
        in_wait = pick_wait(in_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: stall the result stream for a random number of cycles per word
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Predict on each accepted input word
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      tint_req_t r;
      r.brightness  = s_axis_tdata[15:0];
      r.channel_top = s_axis_tdata[31:16];
      r.blend       = s_axis_tdata[39:32];
      r.ramp_level  = s_axis_tdata[47:40];
      levels_due.push_back(split_levels(r));
      in_taken = 1'b1;
    end
  end

  // Check each accepted result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      level_pair_t want;
      out_wait = pick_wait(out_calm);
      if (levels_due.size() == 0) begin
        $display("%0t unexpected result word %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = levels_due.pop_front();
        if (m_axis_tdata[15:0] !== want.warm_level) begin
          $display("%0t warm_level mismatch: expected %0d actual %0d",
                   $time, want.warm_level, m_axis_tdata[15:0]);
          fail_count++;
        end
        if (m_axis_tdata[31:16] !== want.cool_level) begin
          $display("%0t cool_level mismatch: expected %0d actual %0d",
                   $time, want.cool_level, m_axis_tdata[31:16]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed words under the reset register values
    push_req(0, 65535, 0, 1);
    push_req(65535, 65535, 255, 255);
    push_req(65535, 65535, 127, 255);
    push_req(65535, 1, 128, 2);
    push_req(1000, 0, 64, 200);        // zero top forces both channels to zero
    push_req(65535, 30000, 255, 2);    // cool over top spills into warm
    push_req(65535, 30000, 0, 2);      // warm over top spills into cool
    push_req(40000, 65535, 128, 0);    // ramp level zero wraps and gets the boost
    push_req(40000, 65535, 128, 1);
    push_req(65535, 65535, 64, 128);
    push_req(1, 1, 1, 1);
    push_req(12345, 65535, 200, 3);
    push_req(50000, 20000, 100, 1);    // pull-back without boost
    push_req(255, 255, 255, 255);
    push_req(0, 0, 255, 0);
    push_req(65535, 65534, 191, 50);
    push_req(32768, 32768, 129, 254);
    queue_random(120);

    // Gain at its field maximum; bit 7 of the data word is ignored
    set_regs({1'b1, 7'd127}, 8'd0);
    push_req(65535, 1000, 128, 1);     // base driven negative, clamped to zero
    push_req(65535, 1, 127, 2);
    queue_random(160);

    // No boost at all: gain zero, threshold at its maximum
    set_regs(8'd0, 8'hFF);
    push_req(50000, 65535, 128, 0);    // ramp level zero does not pass a 255 threshold
    queue_random(160);

    set_regs(8'd64, 8'd128);
    queue_random(160);

    repeat (4) begin
      set_regs(8'($urandom()), 8'($urandom()));
      queue_random(160);
    end

    set_regs(8'd26, 8'd254);
    queue_random(140);

    drain();
    repeat (2 * NSTAGE) @(posedge clk);
    if (levels_due.size() != 0) begin
      $display("%0t %0d result words never arrived", $time, levels_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[two_channel_tint_blend] OK");
    end else begin
      $display("[two_channel_tint_blend] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("[two_channel_tint_blend] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tctb_pkg.sv
sv/tctb_div255.sv
sv/two_channel_tint_blend.sv
bench/two_channel_tint_blend_tb.sv
